### rtl/sha_pkg.sv
// Package with SHA-256 constants, types and round functions.
package sha_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAD_ONE,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT,
		ST_RESUME
	} state_t;

	function automatic word_t init_hash(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] i);
		word_t k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[i];
	endfunction

	function automatic word_t ror(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t ssig0(input word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	// Request from the controller to the compression core.
	typedef struct packed {
		logic start;
	} core_req_t;

	typedef struct packed {
		logic busy;
	} core_sts_t;

endpackage

### rtl/sha_stream_if.sv
// Valid/ready stream interfaces for the hash engine.
interface sha_in_if;
	logic valid;
	logic ready;
	logic [7:0] msg_byte;
	logic byte_present;
	logic end_of_message;
	modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha_core.sv
// Compression core: block bytes and chaining words in memories, one round a cycle.
module sha_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [5:0]          wr_addr,
	input  logic [7:0]          wr_data,
	input  sha_pkg::core_req_t  req,
	output sha_pkg::core_sts_t  sts,
	input  logic [2:0]          chain_addr,
	input  logic                chain_init,
	output sha_pkg::word_t      chain_data
);
	typedef enum logic [2:0] {
		C_IDLE, C_LOAD, C_ROUND, C_ADD, C_INIT
	} cstate_t;

	logic [7:0]     blk_mem [64];
	sha_pkg::word_t chain_mem [8];

	cstate_t          cst_q;
	logic [6:0]       cnt_q;
	logic [5:0]       rd_addr;
	logic [7:0]       blk_rd_q;
	sha_pkg::word_t   chain_rd_q;
	sha_pkg::word_t   w_q [16];
	sha_pkg::word_t   a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	sha_pkg::word_t   wt, t1, t2, wnew;
	logic [2:0]       cidx;
	logic             chain_we;
	sha_pkg::word_t   chain_wd;
	logic [2:0]       chain_wa;

	// Byte memory: writes from the front end, reads by the loader.
	assign rd_addr = cnt_q[5:0];
	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_mem[wr_addr] <= wr_data;
		end
		blk_rd_q <= blk_mem[rd_addr];
	end

	always_comb begin
		if (cst_q == C_ADD) begin
			cidx = cnt_q[2:0];
		end else if (cst_q == C_LOAD) begin
			cidx = cnt_q[2:0];
		end else begin
			cidx = chain_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_mem[chain_wa] <= chain_wd;
		end
		chain_rd_q <= chain_mem[cidx];
	end

	assign wnew = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];
	assign wt = w_q[0];
	assign t1 = h_q + sha_pkg::bsig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q))
		+ sha_pkg::round_k(cnt_q[5:0]) + wt;
	assign t2 = sha_pkg::bsig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	// Chain writes: initial values, or the sum of the working word and the old word.
	always_comb begin
		chain_we = 1'b0;
		chain_wa = cnt_q[2:0];
		chain_wd = chain_rd_q + a_q;
		if (cst_q == C_INIT) begin
			chain_we = 1'b1;
			chain_wd = sha_pkg::init_hash(cnt_q[2:0]);
		end else if (cst_q == C_ADD && cnt_q != 7'd0) begin
			chain_we = 1'b1;
			chain_wa = cnt_q[2:0] - 3'd1;
		end
	end

	assign chain_data = chain_rd_q;
	assign sts.busy = (cst_q != C_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q <= C_INIT;
			cnt_q <= '0;
		end else begin
			unique case (cst_q)
				C_INIT: begin
					if (cnt_q == 7'd7) begin
						cst_q <= C_IDLE;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				C_IDLE: begin
					cnt_q <= '0;
					if (chain_init) begin
						cst_q <= C_INIT;
					end else if (req.start) begin
						cst_q <= C_LOAD;
					end
				end
				C_LOAD: begin
					// Byte read is registered behind the address; 64 reads, then a drain step for the last byte.
					if (cnt_q == 7'd64) begin
						cst_q <= C_ROUND;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				C_ROUND: begin
					if (cnt_q == 7'd63) begin
						cst_q <= C_ADD;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				default: begin
					if (cnt_q == 7'd8) begin
						cst_q <= C_IDLE;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cst_q == C_LOAD) begin
			if (cnt_q != 7'd0) begin
				// A word is complete in w_q[15] after every fourth byte; it moves
				// down as the first byte of the next word arrives.
				if (cnt_q[1:0] == 2'd1) begin
					for (int i = 0; i < 15; i++) begin
						w_q[i] <= w_q[i + 1];
					end
				end
				w_q[15] <= {w_q[15][23:0], blk_rd_q};
			end
			// Working words come from the chain memory during the first reads.
			if (cnt_q >= 7'd1 && cnt_q <= 7'd8) begin
				h_q <= chain_rd_q;
				g_q <= h_q;
				f_q <= g_q;
				e_q <= f_q;
				d_q <= e_q;
				c_q <= d_q;
				b_q <= c_q;
				a_q <= b_q;
			end
		end else if (cst_q == C_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnew;
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end else if (cst_q == C_ADD && cnt_q != 7'd0) begin
			// Rotate so a_q holds the working word for the next write.
			a_q <= b_q;
			b_q <= c_q;
			c_q <= d_q;
			d_q <= e_q;
			e_q <= f_q;
			f_q <= g_q;
			g_q <= h_q;
		end
	end
endmodule

### rtl/sha256_hash_engine.sv
// SHA-256 engine top level: byte intake, padding sequencer and digest output.
// Usage:
// The input channel takes one transaction per message byte; byte_present
// marks whether msg_byte is used and end_of_message closes the message.
// Bytes go into a 64-entry byte memory. When a block fills, the engine
// stops taking input and runs the compression core: it loads the message
// schedule, runs 64 rounds at one per cycle and folds the result into the
// chaining memory; between blocks bytes are taken at up to one per cycle.
// An end transaction writes the padding one byte per cycle while no
// compression runs (up to 72 bytes, with a second compression when the
// length no longer fits), then presents the eight digest words on the
// output channel, word 0 first, last_word on word 7; a word is read from
// the chaining memory only once the word before it has been taken.
// Each word waits in the output register while the receiver stalls, and
// no input is taken until all eight have gone; the chaining memory is then
// reloaded with the initial values. After reset the chaining memory is
// loaded with them before the first input is taken.
module sha256_hash_engine (
	input logic clk,
	input logic arst_n,
	sha_in_if.sink   in_ch,
	sha_out_if.source out_ch
);
	sha_pkg::state_t st_q, st_d;
	logic [63:0]     len_q;
	logic [63:0]     total_q;
	logic [2:0]      idx_q;
	logic            wr_en;
	logic [7:0]      wr_data;
	logic [5:0]      pos;
	sha_pkg::core_req_t req;
	sha_pkg::core_sts_t sts;
	logic            rd_chain;
	logic            chain_init;
	logic            accept;
	logic            out_v_q;
	logic [31:0]     out_w_q;
	logic            rd_pend_q;
	logic            fold_q;

	assign pos = len_q[8:3];
	assign accept = in_ch.valid && in_ch.ready;

	sha_core u_core (
		.clk, .arst_n, .wr_en, .wr_addr(pos), .wr_data, .req, .sts,
		.chain_addr(idx_q), .chain_init, .chain_data(out_w_q)
	);

	assign in_ch.ready = (st_q == sha_pkg::ST_IDLE) && !sts.busy;

	always_comb begin
		st_d = st_q;
		wr_en = 1'b0;
		wr_data = in_ch.msg_byte;
		req.start = 1'b0;
		rd_chain = 1'b0;
		chain_init = 1'b0;
		unique case (st_q)
			sha_pkg::ST_IDLE: begin
				if (accept) begin
					wr_en = in_ch.byte_present;
					if (in_ch.byte_present && pos == 6'd63) begin
						req.start = 1'b1;
						st_d = in_ch.end_of_message ? sha_pkg::ST_LOAD : sha_pkg::ST_RESUME;
					end else if (in_ch.end_of_message) begin
						st_d = sha_pkg::ST_PAD_ONE;
					end
				end
			end
			sha_pkg::ST_LOAD: begin
				// Wait for a full-block compression before padding.
				if (!sts.busy) begin
					st_d = sha_pkg::ST_PAD_ONE;
				end
			end
			sha_pkg::ST_PAD_ONE: begin
				wr_en = 1'b1;
				wr_data = 8'h80;
				if (pos == 6'd63) begin
					req.start = 1'b1;
					st_d = sha_pkg::ST_ROUND;
				end else begin
					st_d = (pos == 6'd55) ? sha_pkg::ST_PAD_LEN : sha_pkg::ST_PAD_ZERO;
				end
			end
			sha_pkg::ST_ROUND: begin
				if (!sts.busy) begin
					st_d = (pos == 6'd56) ? sha_pkg::ST_PAD_LEN : sha_pkg::ST_PAD_ZERO;
				end
			end
			sha_pkg::ST_PAD_ZERO: begin
				wr_en = 1'b1;
				wr_data = 8'h00;
				if (pos == 6'd63) begin
					req.start = 1'b1;
					st_d = sha_pkg::ST_ROUND;
				end else if (pos == 6'd55) begin
					st_d = sha_pkg::ST_PAD_LEN;
				end
			end
			sha_pkg::ST_PAD_LEN: begin
				wr_en = 1'b1;
				wr_data = total_q[8'd63 - {2'b00, pos[2:0], 3'b000} -: 8];
				if (pos == 6'd63) begin
					req.start = 1'b1;
					st_d = sha_pkg::ST_ADD;
				end
			end
			sha_pkg::ST_ADD: begin
				if (!sts.busy && !req.start && !fold_q) begin
					st_d = sha_pkg::ST_EMIT;
					rd_chain = 1'b1;
				end
			end
			sha_pkg::ST_EMIT: begin
				if (out_ch.ready && out_v_q && idx_q == 3'd7) begin
					chain_init = 1'b1;
					st_d = sha_pkg::ST_RESUME;
				end
			end
			default: begin
				if (!sts.busy && !fold_q) begin
					st_d = sha_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sha_pkg::ST_RESUME;
			len_q <= '0;
			total_q <= '0;
			idx_q <= '0;
			out_v_q <= 1'b0;
			rd_pend_q <= 1'b0;
			fold_q <= 1'b0;
		end else begin
			st_q <= st_d;
			fold_q <= req.start;
			rd_pend_q <= rd_chain || (out_v_q && out_ch.ready && idx_q != 3'd7);
			if (wr_en) begin
				len_q <= len_q + 64'd8;
			end
			if (st_q == sha_pkg::ST_IDLE && accept && in_ch.end_of_message) begin
				total_q <= len_q + (in_ch.byte_present ? 64'd8 : 64'd0);
			end
			if (rd_chain) begin
				idx_q <= '0;
			end
			if (rd_pend_q) begin
				out_v_q <= 1'b1;
			end
			if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
				if (idx_q != 3'd7) begin
					idx_q <= idx_q + 3'd1;
				end else begin
					idx_q <= '0;
					len_q <= '0;
				end
			end
		end
	end

	// The chain memory read address is idx_q; the word appears in the next cycle.
	assign out_ch.valid = out_v_q;
	assign out_ch.digest_word = out_w_q;
	assign out_ch.word_index = idx_q;
	assign out_ch.last_word = (idx_q == 3'd7);

	a_no_accept_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !in_ch.ready)
		else $error("input taken while digest pending");
	a_no_core_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !wr_en)
		else $error("byte written during compression");
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_ch.ready && idx_q != 3'd7) |=> ##1 (idx_q == $past(idx_q, 2) + 3'd1))
		else $error("digest word order broken");
endmodule

### dv/sha256_hash_engine_test.sv
// Self-checking testbench for the SHA-256 hash engine.
`timescale 1ns / 100ps

module sha256_hash_engine_test;

	localparam int unsigned IdleLimit = 20000;

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0] word_index;
		logic last_word;
	} digest_item_t;

	class digest_scoreboard;
		sha_pkg::word_t chain [8];
		logic [7:0] blk [64];
		logic [63:0] bit_count;
		digest_item_t pending [$];
		int errors;

		function void restart();
			for (int i = 0; i < 8; i++) chain[i] = init_value(i);
			bit_count = '0;
		endfunction

		function sha_pkg::word_t init_value(int i);
			sha_pkg::word_t iv [8];
			iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			return iv[i];
		endfunction

		function sha_pkg::word_t rot(sha_pkg::word_t x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			sha_pkg::word_t w [64];
			sha_pkg::word_t v [8];
			sha_pkg::word_t t1, t2;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++)
				w[i] = (rot(w[i-2], 17) ^ rot(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
					+ (rot(w[i-15], 7) ^ rot(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
			v = chain;
			for (int i = 0; i < 64; i++) begin
				t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(6'(i)) + w[i];
				t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++) chain[i] += v[i];
		endfunction

		function void append(logic [7:0] b);
			int pos;
			pos = bit_count[8:3];
			blk[pos] = b;
			bit_count += 64'd8;
			if (pos == 63) compress();
		endfunction

		function void note_input(logic [7:0] b, logic present, logic eom);
			logic [63:0] total;
			digest_item_t d;
			if (present) append(b);
			if (!eom) return;
			total = bit_count;
			append(8'h80);
			while (bit_count[8:3] != 56) append(8'h00);
			for (int i = 0; i < 8; i++) append(total[56 - 8*i +: 8]);
			for (int i = 0; i < 8; i++) begin
				d.digest_word = chain[i];
				d.word_index = 3'(i);
				d.last_word = (i == 7);
				pending.push_back(d);
			end
			restart();
		endfunction

		function void check_word(logic [31:0] dw, logic [2:0] idx, logic lw);
			digest_item_t e;
			if (pending.size() == 0) begin
				$display("%t: unexpected digest word %h idx %0d", $time, dw, idx);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (dw !== e.digest_word || idx !== e.word_index || lw !== e.last_word) begin
				$display("%t: mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
					e.digest_word, e.word_index, e.last_word, dw, idx, lw);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	sha_in_if in_ch ();
	sha_out_if out_ch ();
	digest_scoreboard digests;
	int idle_cycles;

	sha256_hash_engine uut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// Monitor: inputs and outputs are both taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (in_ch.valid && in_ch.ready) begin
				digests.note_input(in_ch.msg_byte, in_ch.byte_present, in_ch.end_of_message);
			end
			if (out_ch.valid && out_ch.ready) begin
				digests.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
			end
			if (idle_cycles >= IdleLimit) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Receiver stalls in a pattern of its own: long stretches always ready,
	// then stretches with random back-pressure.
	always @(negedge clk) begin
		if (!arst_n) out_ch.ready <= 1'b0;
		else if (($time / 1000) % 3 == 0) out_ch.ready <= 1'b1;
		else out_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	int burst_left;

	task automatic send(logic [7:0] b, logic present, logic eom);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				in_ch.msg_byte <= $urandom;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.msg_byte <= b;
		in_ch.byte_present <= present;
		in_ch.end_of_message <= eom;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) send($urandom, 1'b0, 1'b0);
			if (i == len - 1 && $urandom_range(0, 1)) begin
				send($urandom, 1'b1, 1'b1);
				return;
			end
			send($urandom, 1'b1, 1'b0);
		end
		send($urandom, 1'b0, 1'b1);
	endtask

	int sent;
	int len;

	initial begin
		digests = new();
		digests.restart();
		burst_left = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.msg_byte = 8'h00;
		in_ch.byte_present = 1'b0;
		in_ch.end_of_message = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty message, idle item, byte extremes, end with a byte, then abc.
		send(8'hff, 1'b0, 1'b1);
		send(8'h00, 1'b0, 1'b0);
		send(8'h00, 1'b1, 1'b0);
		send(8'hff, 1'b1, 1'b0);
		send(8'h5a, 1'b0, 1'b0);
		send(8'ha5, 1'b1, 1'b1);
		send(8'h61, 1'b1, 1'b0);
		send(8'h62, 1'b1, 1'b0);
		send(8'h63, 1'b1, 1'b0);
		send(8'h00, 1'b0, 1'b1);

		// Random messages: short ones, and lengths around the padding boundaries.
		sent = 0;
		while (sent < 210) begin
			case ($urandom_range(0, 4))
				0: len = $urandom_range(54, 57);
				1: len = $urandom_range(62, 66);
				2: len = $urandom_range(118, 121);
				default: len = $urandom_range(0, 20);
			endcase
			if (sent + len + 1 > 210) len = 210 - sent - 1;
			send_message(len);
			sent += len + 1;
		end
		in_ch.valid <= 1'b0;

		while (digests.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (digests.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/sha_pkg.sv
rtl/sha_stream_if.sv
rtl/sha_core.sv
rtl/sha256_hash_engine.sv
dv/sha256_hash_engine_test.sv
